FILE: rtl/tmp_pkg.sv
// Shared types, codes and fixed-point helpers for the trapezoid motion profile block.
// Used by tmp_cfg, tmp_core and trapezoid_motion_profile; depends on nothing.
`default_nettype none

package tmp_pkg;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int REG_W      = 31;
    localparam int STEP_W     = 27;
    localparam int PHASE_W    = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_REST   = 2'd3;

    // Register indexes
    localparam logic REG_MAX_ACCEL    = 1'b0;
    localparam logic REG_MAX_VELOCITY = 1'b1;

    // ceil(2^34 / 5): exact quotient by 5 for any operand below 2^32
    localparam logic [31:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    // Limits held after the profile step is applied
    typedef struct packed {
        logic [STEP_W-1:0] accel_step;    // max_accel / 40
        logic [REG_W-1:0]  max_velocity;
    } cfg_t;

    // Magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] neg;
        neg = DATA_W'(-v);
        return v[DATA_W-1] ? neg : DATA_W'(v);
    endfunction

    // floor(m / 40): shift out 3 bits, then multiply by the reciprocal of 5
    function automatic logic [STEP_W-1:0] div40_mag(input logic [DATA_W-1:0] m);
        logic [60:0] x;
        logic [60:0] prod;
        x    = {32'd0, m[DATA_W-1:3]};
        prod = x * {29'd0, DIV5_MUL};
        return prod[DIV5_SHIFT +: STEP_W];
    endfunction

    // Clamp a 33-bit signed sum to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
        logic signed [DATA_W-1:0] r;
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tmp_cfg.sv
// Configuration registers of the motion profile block.
// Depends on tmp_pkg; stores max_accel pre-scaled to a per-tick step.
`default_nettype none

module tmp_cfg import tmp_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [REG_W-1:0] cfg_wdata,
    output cfg_t                  cfg_o
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Scale the acceleration to its per-tick step at write time
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_ACCEL:    cfg_next.accel_step   = div40_mag({1'b0, cfg_wdata});
                REG_MAX_VELOCITY: cfg_next.max_velocity = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/tmp_core.sv
// Profile state, one-tick update logic and the result register.
// Depends on tmp_pkg; fed by the input register in the top level.
`default_nettype none

module tmp_core import tmp_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cfg_t                     cfg_i,
    input  wire logic                     step_valid,
    input  wire logic signed [DATA_W-1:0] step_target,
    output logic                          step_ready,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // m_tdata: position_setpoint[31:0], velocity_setpoint[63:32], phase[65:64],
    //          moving_forward[66], zero fill [71:67]
    output logic [M_TDATA_W-1:0]          m_tdata
);

    // Profile state
    logic signed [DATA_W-1:0] pos_reg, pos_next;
    logic signed [DATA_W-1:0] vel_reg, vel_next;
    logic signed [DATA_W-1:0] prev_target_reg;
    logic signed [DATA_W-1:0] accel_dist_reg, accel_dist_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [PHASE_W-1:0]       prev_phase_reg;
    logic                     fwd_reg, fwd_next;

    // Result register
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    logic                     fire;
    logic                     restart;
    logic signed [DATA_W-1:0] p0, v0;
    logic [PHASE_W-1:0]       ph0, ph1;
    logic signed [DATA_W:0]   err;
    logic signed [DATA_W:0]   dist_ext;
    logic [STEP_W-1:0]        step_a;
    logic signed [STEP_W:0]   dv;
    logic [DATA_W-1:0]        v0_mag;
    logic signed [DATA_W-1:0] v_sum;
    logic [STEP_W-1:0]        q_mag;
    logic signed [STEP_W:0]   q;
    logic signed [DATA_W-1:0] p_sum;

    assign step_ready = !m_valid_reg || m_tready;
    assign fire       = step_valid && step_ready;

    // Evaluate one tick of the profile
    always_comb begin
        restart  = step_target != prev_target_reg;
        p0       = restart ? '0 : pos_reg;
        v0       = restart ? '0 : vel_reg;
        ph0      = restart ? PH_ACCEL : phase_reg;
        err      = {step_target[DATA_W-1], step_target} - {pos_reg[DATA_W-1], pos_reg};

        // Direction follows the sign of the target; zero holds it
        if (step_target[DATA_W-1]) begin
            fwd_next = 1'b0;
        end else if (step_target != '0) begin
            fwd_next = 1'b1;
        end else begin
            fwd_next = fwd_reg;
        end
        step_a = (step_target == '0) ? '0 : cfg_i.accel_step;

        // Speed limit forces cruise outside decel
        v0_mag = mag32(v0);
        ph1    = ph0;
        if (v0_mag >= {1'b0, cfg_i.max_velocity} && ph0 != PH_DECEL) begin
            ph1 = PH_CRUISE;
        end

        // Latch the distance used to accelerate on entry to cruise
        accel_dist_next = accel_dist_reg;
        if (ph1 == PH_CRUISE && prev_phase_reg == PH_ACCEL) begin
            accel_dist_next = p0;
        end
        dist_ext = {accel_dist_next[DATA_W-1], accel_dist_next};

        phase_next = ph1;
        dv         = '0;
        case (ph1)
            PH_ACCEL: begin
                if ({mag32(p0), 1'b0} > {1'b0, mag32(step_target)}) begin
                    phase_next = PH_DECEL;
                end
                dv = fwd_next ? $signed({1'b0, step_a}) : -$signed({1'b0, step_a});
            end
            PH_CRUISE: begin
                if (fwd_next ? (err <= dist_ext) : (err >= dist_ext)) begin
                    phase_next = PH_DECEL;
                end
            end
            PH_DECEL: begin
                if (fwd_next ? v0[DATA_W-1] : (!v0[DATA_W-1] && v0 != '0)) begin
                    phase_next = PH_REST;
                end
                dv = fwd_next ? -$signed({1'b0, step_a}) : $signed({1'b0, step_a});
            end
            default: begin
                dv = '0;
            end
        endcase

        // Integrate velocity, then position with the new velocity
        v_sum    = sat33({v0[DATA_W-1], v0} + {{(DATA_W-STEP_W){dv[STEP_W]}}, dv});
        vel_next = (ph1 == PH_REST) ? '0 : v_sum;
        q_mag    = div40_mag(mag32(vel_next));
        q        = vel_next[DATA_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        p_sum    = sat33({p0[DATA_W-1], p0} + {{(DATA_W-STEP_W){q[STEP_W]}}, q});
        pos_next = (ph1 == PH_REST) ? p0 : p_sum;
    end

    // Commit state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            vel_reg         <= '0;
            prev_target_reg <= '0;
            accel_dist_reg  <= '0;
            phase_reg       <= PH_REST;
            prev_phase_reg  <= PH_REST;
            fwd_reg         <= 1'b0;
        end else if (fire) begin
            pos_reg         <= pos_next;
            vel_reg         <= vel_next;
            prev_target_reg <= step_target;
            accel_dist_reg  <= accel_dist_next;
            phase_reg       <= phase_next;
            prev_phase_reg  <= phase_next;
            fwd_reg         <= fwd_next;
        end
    end

    // Hold the result beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_ready) begin
            m_valid_reg <= step_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {5'd0, fwd_next, phase_next, vel_next, pos_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // A tick that stays in rest clears the velocity
    a_rest_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ph1 == PH_REST |=> vel_reg == '0 && phase_reg == PH_REST)
        else $error("rest tick left a nonzero velocity");

    // State only moves on an accepted tick
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(pos_reg) && $stable(vel_reg) && $stable(phase_reg))
        else $error("profile state changed without a tick");

    // A new target never lands in rest on the same tick
    a_restart_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && restart |=> phase_reg != PH_REST)
        else $error("restart ended in rest");

    // Result register mirrors the committed state
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_data_reg[31:0] == pos_reg && m_data_reg[63:32] == vel_reg)
        else $error("result beat differs from profile state");
`endif

endmodule

`default_nettype wire

FILE: rtl/trapezoid_motion_profile.sv
// Top level of the trapezoid motion profile generator: input register and hookup.
// Depends on tmp_pkg, tmp_cfg and tmp_core.
//
// Usage: each s_ beat is one 25 ms control tick carrying target_distance
// (Q16.16, signed). Each tick yields exactly one m_ beat with the profiled
// position and velocity setpoints, the phase (accel, cruise, decel, rest)
// and the direction flag. A target that differs from the previous one
// restarts the profile from zero in accel.
// Path: an accepted beat passes the input register, then the update logic
// into the result register, before it is presented on m_.
// Throughput: one tick per cycle while m_ is not stalled; the state update
// loop is combinational, with one reciprocal multiply on the position step.
// Configuration: cfg_wr_en with cfg_index 0 writes max_accel, 1 writes
// max_velocity; write only while no tick is in flight.
// Reset (aresetn low, synchronous): config, valid flags and profile state clear;
// data registers are not reset; phase goes to rest, both channels drain empty.
// Stall: while m_tready is low the result beat holds; one further tick
// waits in the input register, then s_tready drops.
`default_nettype none

module trapezoid_motion_profile import tmp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata,
    // s_tdata: target_distance[31:0]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: position_setpoint[31:0], velocity_setpoint[63:32], phase[65:64],
    //          moving_forward[66], zero fill [71:67]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    cfg_t                     cfg;
    logic                     in_valid_reg;
    logic signed [DATA_W-1:0] in_target_reg;
    logic                     step_ready;

    tmp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_o     (cfg)
    );

    // Input register: refill when empty or whenever the held beat moves on
    assign s_tready = !in_valid_reg || step_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_target_reg <= s_tdata[DATA_W-1:0];
        end
    end

    tmp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_i       (cfg),
        .step_valid  (in_valid_reg),
        .step_target (in_target_reg),
        .step_ready  (step_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
